// File: hw/rtl/btr_pkg.sv
// Shared types, register indexes and the 5x8 font table of the text renderer.
`timescale 1ns / 1ps
package btr_pkg;

    localparam int CHAR_W     = 8;
    localparam int COORD_W    = 9;
    localparam int SCALE_W    = 4;
    localparam int HEIGHT_W   = 7;
    localparam int COLOR_W    = 16;
    localparam int GLYPH_IDX_W = 7;
    localparam int GLYPH_BITS = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int M_TDATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'd126;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_QMARK = 7'd31;

    typedef struct packed {
        logic [7:0]         col;
        logic [7:0]         row;
        logic [SCALE_W-1:0] scale;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } btr_job_t;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SCALE_W-1:0]  w;
        logic [HEIGHT_W-1:0] h;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } btr_rect_t;

    // Columns left to right, column 0 in the top byte; bit 0 of a column is the top row.
    function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [GLYPH_IDX_W-1:0] idx);
        logic [GLYPH_BITS-1:0] g;
        unique case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005F0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14;
            7'd4:  g = 40'h242A7F2A12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001C224100;
            7'd9:  g = 40'h0041221C00;
            7'd10: g = 40'h082A1C2A08;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3E5149453E;
            7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454B31;
            7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3C4A494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291E;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0008142241;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h4122140800;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324979413E;
            7'd33: g = 40'h7E1111117E;
            7'd34: g = 40'h7F49494936;
            7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C;
            7'd37: g = 40'h7F49494941;
            7'd38: g = 40'h7F09090901;
            7'd39: g = 40'h3E4141497A;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01;
            7'd43: g = 40'h7F08142241;
            7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F020C027F;
            7'd46: g = 40'h7F0408107F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906;
            7'd49: g = 40'h3E4151215E;
            7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h3F4038403F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007F414100;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h0041417F00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087E090102;
            7'd71: g = 40'h0C5252523E;
            7'd72: g = 40'h7F08040478;
            7'd73: g = 40'h00447D4000;
            7'd74: g = 40'h2040443D00;
            7'd75: g = 40'h7F10284400;
            7'd76: g = 40'h00417F4000;
            7'd77: g = 40'h7C04180478;
            7'd78: g = 40'h7C08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7C14141408;
            7'd81: g = 40'h081414187C;
            7'd82: g = 40'h7C08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020;
            7'd85: g = 40'h3C4040207C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0C5050503C;
            7'd90: g = 40'h4464544C44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h1008081008;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

// File: hw/rtl/bitmap_text_renderer_core.sv
// Top level of the bitmap text renderer: config registers, cursor and glyph fetch.
//
// Text enters one byte per word on the s_ channel (s_tdata = char_code,
// s_tuser = start_text). Each drawn character leaves as a run of
// rectangle-fill words on the m_ channel, the final one flagged by m_tlast.
// Registers are written over the cfg_ channel (cfg_ready is always high).
//
// A newline, a carriage return or a character whose cursor lies off screen
// yields no word. A drawn character is read from the font ROM, then walked
// one dot per cycle through the dot sequencer when the receiver keeps up:
// up to 41 rectangle words per character. The first word passes the ROM
// read, the sequencer's FETCH and DRAW states and its output register.
// s_tready is high only while the sequencer is idle.
//
// A stalled m_ channel holds the output register and freezes the sequencer.
// Reset clears the cursor to (0,0) and loads the register defaults:
// origin (0,0), white on black, scale 1.
`timescale 1ns / 1ps
module bitmap_text_renderer_core #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [btr_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] char_code
    input  logic                               s_tuser,   // [0] start_text
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [8:0] rect_x, [17:9] rect_y, [21:18] rect_w, [28:22] rect_h, [44:29] rect_color
    output logic [btr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [btr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import btr_pkg::*;

    localparam logic [9:0] SW = 10'(SCREEN_WIDTH);
    localparam logic [8:0] SH = 9'(SCREEN_HEIGHT);

    logic [7:0]          origin_x_reg, origin_y_reg;
    logic [COLOR_W-1:0]  fg_reg, bg_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [7:0]          col_reg, col_next;
    logic [7:0]          row_reg, row_next;

    logic                accept;
    logic [SCALE_W-1:0]  s_eff;
    logic [6:0]          s6, s8;
    logic [7:0]          col0, row0, col_adv, row_nl;
    logic                is_lf, is_cr, printable, on_screen, wrap, draw;
    logic [GLYPH_IDX_W-1:0] glyph_idx;
    logic [GLYPH_BITS-1:0]  glyph;
    logic                raster_idle;
    btr_job_t            job;
    btr_rect_t           rect;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = raster_idle;
    assign cfg_ready = 1'b1;

    always_comb begin
        s_eff     = (scale_reg == '0) ? 4'd1 : scale_reg;
        s8        = {s_eff, 3'b000};
        s6        = {1'b0, s_eff, 2'b00} + {2'b00, s_eff, 1'b0};
        col0      = s_tuser ? origin_x_reg : col_reg;
        row0      = s_tuser ? origin_y_reg : row_reg;
        is_lf     = (s_tdata == CHAR_LF);
        is_cr     = (s_tdata == CHAR_CR);
        printable = (s_tdata >= CHAR_FIRST) && (s_tdata <= CHAR_LAST);
        glyph_idx = printable ? (s_tdata[GLYPH_IDX_W-1:0] - CHAR_FIRST[GLYPH_IDX_W-1:0])
                              : GLYPH_QMARK;
        on_screen = ({2'b00, col0} < SW) && ({1'b0, row0} < SH);
        col_adv   = col0 + {1'b0, s6};
        row_nl    = row0 + {1'b0, s8};
        wrap      = $signed({2'b00, col_adv}) > $signed(SW - {3'b000, s6});
        draw      = !is_lf && !is_cr && on_screen;

        if (is_lf) begin
            col_next = origin_x_reg;
            row_next = row_nl;
        end else if (is_cr) begin
            col_next = col0;
            row_next = row0;
        end else if (wrap) begin
            col_next = origin_x_reg;
            row_next = row_nl;
        end else begin
            col_next = col_adv;
            row_next = row0;
        end

        job.col   = col0;
        job.row   = row0;
        job.scale = s_eff;
        job.fg    = fg_reg;
        job.bg    = bg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            fg_reg       <= 16'hFFFF;
            bg_reg       <= '0;
            scale_reg    <= 4'd1;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: origin_x_reg <= cfg_data[7:0];
                    CFG_ORIGIN_Y: origin_y_reg <= cfg_data[7:0];
                    CFG_FG_COLOR: fg_reg       <= cfg_data;
                    CFG_BG_COLOR: bg_reg       <= cfg_data;
                    CFG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    btr_font_rom u_font_rom (
        .aclk    (aclk),
        .rd_en   (accept && draw),
        .rd_addr (glyph_idx),
        .rd_data (glyph)
    );

    btr_raster u_raster (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && draw),
        .job     (job),
        .glyph   (glyph),
        .idle    (raster_idle),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_rect  (rect)
    );

    assign m_tdata = {3'b000, rect.color, rect.h, rect.w, rect.y, rect.x};
    assign m_tlast = rect.last;

endmodule

// File: hw/rtl/btr_font_rom.sv
// Synchronous font ROM: one glyph of five column bytes per read, registered on rd_en.
`timescale 1ns / 1ps
module btr_font_rom (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [btr_pkg::GLYPH_IDX_W-1:0]   rd_addr,
    output logic [btr_pkg::GLYPH_BITS-1:0]    rd_data
);
    import btr_pkg::*;

    logic [GLYPH_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= font_glyph(rd_addr);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/btr_raster.sv
// Dot sequencer: walks 40 glyph dots and the spacing column, at most one rectangle per step.
`timescale 1ns / 1ps
module btr_raster (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  btr_pkg::btr_job_t               job,
    input  logic [btr_pkg::GLYPH_BITS-1:0]  glyph,
    output logic                            idle,
    output logic                            m_valid,
    input  logic                            m_ready,
    output btr_pkg::btr_rect_t              m_rect
);
    import btr_pkg::*;

    localparam logic [5:0] DOTS = 6'd40;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_DRAW  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    btr_job_t               job_reg;
    logic [GLYPH_BITS-1:0]  bits_reg, bits_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [2:0]             dot_row_reg, dot_row_next;
    logic [6:0]             x_off_reg, x_off_next;
    logic [6:0]             y_off_reg, y_off_next;
    logic                   out_valid_reg;
    btr_rect_t              out_rect_reg;

    logic                   step;
    logic                   fill_bg;
    logic                   emit;
    btr_rect_t              rect;

    always_comb begin
        step         = (state_reg == ST_DRAW) && (!out_valid_reg || m_ready);
        fill_bg      = (job_reg.fg != job_reg.bg);
        state_next   = state_reg;
        bits_next    = bits_reg;
        cnt_next     = cnt_reg;
        dot_row_next = dot_row_reg;
        x_off_next   = x_off_reg;
        y_off_next   = y_off_reg;
        emit         = 1'b0;
        rect.x       = {1'b0, job_reg.col} + {2'b00, x_off_reg};
        rect.y       = {1'b0, job_reg.row} + {2'b00, y_off_reg};
        rect.w       = job_reg.scale;
        rect.h       = {3'b000, job_reg.scale};
        rect.color   = bits_reg[0] ? job_reg.fg : job_reg.bg;
        rect.last    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                bits_next    = {glyph[7:0], glyph[15:8], glyph[23:16],
                                glyph[31:24], glyph[39:32]};
                cnt_next     = '0;
                dot_row_next = '0;
                x_off_next   = '0;
                y_off_next   = '0;
                state_next   = ST_DRAW;
            end
            ST_DRAW: begin
                if (step) begin
                    if (cnt_reg == DOTS) begin
                        emit       = fill_bg;
                        rect.y     = {1'b0, job_reg.row};
                        rect.h     = {job_reg.scale, 3'b000};
                        rect.color = job_reg.bg;
                        rect.last  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (!fill_bg && (bits_reg == '0)) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit      = bits_reg[0] || fill_bg;
                        rect.last = !fill_bg && (bits_reg[GLYPH_BITS-1:1] == '0);
                        bits_next = {1'b0, bits_reg[GLYPH_BITS-1:1]};
                        cnt_next  = cnt_reg + 6'd1;
                        if (dot_row_reg == 3'd7) begin
                            dot_row_next = '0;
                            y_off_next   = '0;
                            x_off_next   = x_off_reg + {3'b000, job_reg.scale};
                        end else begin
                            dot_row_next = dot_row_reg + 3'd1;
                            y_off_next   = y_off_reg + {3'b000, job_reg.scale};
                        end
                        if (rect.last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && (state_reg == ST_IDLE)) begin
            job_reg <= job;
        end
        bits_reg    <= bits_next;
        cnt_reg     <= cnt_next;
        dot_row_reg <= dot_row_next;
        x_off_reg   <= x_off_next;
        y_off_reg   <= y_off_next;
        if (emit) begin
            out_rect_reg <= rect;
        end
    end

    assign idle    = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_rect  = out_rect_reg;

endmodule

// File: hw/rtl/btr_checker.sv
// Port-level checks of the text renderer, bound to the top level.
`timescale 1ns / 1ps
module btr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [btr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);
    import btr_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    a_width_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[21:18] != 4'd0)
        else $error("rectangle width zero");

    a_height_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[28:22] == {3'b000, m_tdata[21:18]}) ||
                     (m_tdata[28:22] == {m_tdata[21:18], 3'b000}))
        else $error("rectangle height is neither scale nor eight times scale");

    a_busy_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a character run is still open");

endmodule

bind bitmap_text_renderer_core btr_checker u_btr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
